FILE: src/sod_pkg.sv
// Shared types and constants for the slot occupancy debouncer.
`default_nettype none

package sod_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OCC_W     = $clog2(NUM_SLOTS + 1);

    localparam int IDX_W     = 3;
    localparam int DIST_W    = 16;
    localparam int CONF_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 8;
    localparam int OCC_OUT_W = 3;

    localparam logic [DIST_W-1:0] PRESENCE_DIST_RST = 16'd10;
    localparam logic [CONF_W-1:0] CONF_NEEDED_RST   = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENCE_DIST = 1'b0,
        CFG_CONF_NEEDED   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_EMPTY    = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_ERROR    = 2'd2
    } t_slot_state;

    typedef logic [CONF_W-1:0] t_conf_cnt;

    typedef struct packed {
        t_slot_state state;
        t_conf_cnt   cnt;
        logic        changed;
        logic        occ_inc;
        logic        occ_dec;
    } t_slot_upd;

endpackage

`default_nettype wire

FILE: src/slot_occupancy_debouncer_unit.sv
// Top level of the slot occupancy debouncer: input register, slot table, result register.
// An accepted input word goes through the input register, then the result register,
// before its result word is valid.
// Throughput: one word per cycle when not stalled at the output; the slot table is read
// and written in the same cycle as the update, so consecutive words for one slot see each other at once.
// Reset (synchronous, active low): all slots empty, counters zero, occupancy zero,
// presence distance 10, confidence threshold 3, both stages empty.
`default_nettype none

module slot_occupancy_debouncer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // s_axis_tdata: [2:0] slot_index, [18:3] distance, [23:19] zero
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [sod_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // m_axis_tdata: [1:0] slot state, [2] change flag, [5:3] occupied slots,
    //               [6] lot full, [7] bad index
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [sod_pkg::M_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [sod_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sod_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);

    typedef logic [sod_pkg::SLOT_W-1:0] t_slot_addr;

    logic [sod_pkg::DIST_W-1:0] r_presence_dist;
    logic [sod_pkg::CONF_W-1:0] r_conf_needed;

    logic                       r_in_valid;
    logic [sod_pkg::IDX_W-1:0]  r_in_idx;
    logic [sod_pkg::DIST_W-1:0] r_in_dist;

    sod_pkg::t_slot_state       r_state [sod_pkg::NUM_SLOTS];
    sod_pkg::t_conf_cnt         r_cnt   [sod_pkg::NUM_SLOTS];
    logic [sod_pkg::OCC_W-1:0]  r_occ;
    logic [sod_pkg::OCC_W-1:0]  n_occ;

    logic                       r_out_valid;
    logic [sod_pkg::M_DATA_W-1:0] r_out_data;
    logic [sod_pkg::M_DATA_W-1:0] n_out_data;

    logic                       out_free;
    logic                       fire;
    logic                       bad;
    t_slot_addr                 addr;
    sod_pkg::t_slot_state       cur_state;
    sod_pkg::t_conf_cnt         cur_cnt;
    sod_pkg::t_slot_upd         upd;
    sod_pkg::t_slot_state       res_state;
    logic                       res_changed;
    logic [sod_pkg::OCC_OUT_W-1:0] res_occ;
    logic                       res_full;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presence_dist <= sod_pkg::PRESENCE_DIST_RST;
            r_conf_needed   <= sod_pkg::CONF_NEEDED_RST;
        end else if (i_cfg_wr_en) begin
            unique case (sod_pkg::t_cfg_idx'(i_cfg_index))
                sod_pkg::CFG_PRESENCE_DIST: r_presence_dist <= i_cfg_wdata;
                sod_pkg::CFG_CONF_NEEDED:
                    r_conf_needed <= i_cfg_wdata[sod_pkg::CONF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_idx  <= s_axis_tdata[sod_pkg::IDX_W-1:0];
            r_in_dist <= s_axis_tdata[sod_pkg::IDX_W +: sod_pkg::DIST_W];
        end
    end

    assign bad       = (32'(r_in_idx) >= 32'(sod_pkg::NUM_SLOTS));
    assign addr      = t_slot_addr'(r_in_idx);
    assign cur_state = bad ? sod_pkg::ST_EMPTY : r_state[addr];
    assign cur_cnt   = bad ? '0 : r_cnt[addr];

    sod_slot_update u_upd (
        .i_distance      (r_in_dist),
        .i_presence_dist (r_presence_dist),
        .i_conf_needed   (r_conf_needed),
        .i_cur_state     (cur_state),
        .i_cur_cnt       (cur_cnt),
        .o_upd           (upd)
    );

    always_comb begin
        n_occ = r_occ;
        if (!bad) begin
            if (upd.occ_inc) begin
                n_occ = r_occ + 1'b1;
            end else if (upd.occ_dec) begin
                n_occ = r_occ - 1'b1;
            end
        end
    end

    always_comb begin
        res_state   = bad ? sod_pkg::ST_EMPTY : upd.state;
        res_changed = !bad && upd.changed;
        res_occ     = (32'(n_occ) > 7) ? 3'd7 : 3'(n_occ);
        res_full    = (32'(n_occ) == 32'(sod_pkg::NUM_SLOTS));
        n_out_data  = {bad, res_full, res_occ, res_changed, res_state};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sod_pkg::NUM_SLOTS; i++) begin
                r_state[i] <= sod_pkg::ST_EMPTY;
                r_cnt[i]   <= '0;
            end
            r_occ <= '0;
        end else if (fire && !bad) begin
            r_state[addr] <= upd.state;
            r_cnt[addr]   <= upd.cnt;
            r_occ         <= n_occ;
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

FILE: src/sod_slot_update.sv
// Debounce update for one slot: counter step, state decision, occupancy delta.
`default_nettype none

module sod_slot_update (
    input  wire logic [sod_pkg::DIST_W-1:0] i_distance,
    input  wire logic [sod_pkg::DIST_W-1:0] i_presence_dist,
    input  wire logic [sod_pkg::CONF_W-1:0] i_conf_needed,
    input  wire sod_pkg::t_slot_state       i_cur_state,
    input  wire sod_pkg::t_conf_cnt         i_cur_cnt,
    output sod_pkg::t_slot_upd              o_upd
);

    logic                 present;
    logic                 dist_zero;
    sod_pkg::t_conf_cnt   cap;
    sod_pkg::t_conf_cnt   cnt;
    sod_pkg::t_slot_state state;

    assign dist_zero = (i_distance == '0);
    assign present   = !dist_zero && (i_distance <= i_presence_dist);
    // cap is one above the threshold, clipped to the counter width
    assign cap       = (i_conf_needed == '1) ? '1 : i_conf_needed + 1'b1;

    always_comb begin
        cnt = i_cur_cnt;
        if (present) begin
            if (i_cur_cnt < cap) begin
                cnt = i_cur_cnt + 1'b1;
            end
        end else if (i_cur_cnt != '0) begin
            cnt = i_cur_cnt - 1'b1;
        end
    end

    always_comb begin
        priority if (cnt >= i_conf_needed) begin
            state = sod_pkg::ST_OCCUPIED;
        end else if (cnt == '0) begin
            state = sod_pkg::ST_EMPTY;
        end else begin
            state = i_cur_state;
        end
        // no echo on a drained counter flags the sensor unless already occupied
        if (dist_zero && (i_cur_state != sod_pkg::ST_OCCUPIED) && (cnt == '0)) begin
            state = sod_pkg::ST_ERROR;
        end
    end

    assign o_upd.state   = state;
    assign o_upd.cnt     = cnt;
    assign o_upd.changed = (state != i_cur_state);
    assign o_upd.occ_inc = (state == sod_pkg::ST_OCCUPIED) &&
                           (i_cur_state != sod_pkg::ST_OCCUPIED);
    assign o_upd.occ_dec = (state != sod_pkg::ST_OCCUPIED) &&
                           (i_cur_state == sod_pkg::ST_OCCUPIED);

endmodule

`default_nettype wire

FILE: src/sod_checker.sv
// Port-level assertions for the slot occupancy debouncer, bound to the top level.
`default_nettype none

module sod_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [sod_pkg::M_DATA_W-1:0]  m_axis_tdata
);

    localparam logic [sod_pkg::OCC_OUT_W-1:0] FULL_COUNT =
        sod_pkg::OCC_OUT_W'((sod_pkg::NUM_SLOTS > 7) ? 7 : sod_pkg::NUM_SLOTS);

    // a bad index leaves the state fields at their idle values
    a_bad_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7]) |-> (m_axis_tdata[2:0] == 3'd0))
        else $error("bad index word carries a state or change");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |-> (m_axis_tdata[5:3] == FULL_COUNT))
        else $error("lot full with wrong occupied count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[5:3]) <= sod_pkg::NUM_SLOTS))
        else $error("occupied count above slot count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind slot_occupancy_debouncer_unit sod_checker u_sod_checker (.*);

`default_nettype wire
